// ===== design/dsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_pkg
// shared constants, codes and types of the dedup slot allocator
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int SLOT_COUNT   = 32;
    localparam int SLOT_BASE    = 1024;
    localparam int KEY_BITS     = 64;
    localparam int NUMBER_LIMIT = 2048;

    // slots whose number would reach the limit do not exist
    localparam int USABLE_SLOTS = (SLOT_COUNT < NUMBER_LIMIT - SLOT_BASE) ?
                                  SLOT_COUNT : NUMBER_LIMIT - SLOT_BASE;

    localparam int IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W    = $clog2(USABLE_SLOTS + 1);
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int NUM_W    = 11;
    localparam int REL_W    = NUM_W + 1;

    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FAIL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RSV,
        ST_OUT
    } state_t;

endpackage : dsa_pkg
`default_nettype wire

// ===== design/dsa_key_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_key_ram
// single port write, single port read key memory with registered read data
// ----------------------------------------------------------------------------
module dsa_key_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : dsa_key_ram
`default_nettype wire

// ===== design/dedup_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// resolve runs from accept to result word with one key memory read per usable slot
//   (the read data is registered behind the address)
// reserve checks one flag pair per cycle, from the highest usable slot down
// release, clear and an empty key go straight to the result; one word in flight at a time
// reset clears all key valid bits and reserved flags at once, no clearing pass
// ----------------------------------------------------------------------------
// dedup_slot_allocator_unit
// slot table with key dedup, lowest free claim and highest free reservation
// ----------------------------------------------------------------------------
module dedup_slot_allocator_unit
    import dsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [63:0]         lookup_key,
    input  wire logic [NUM_W-1:0]    release_number,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [STATUS_W-1:0] status,
    output logic      [NUM_W-1:0]    slot_number
);

    state_t state_reg, state_next;

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      rsv_idx_reg, rsv_idx_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [NUM_W-1:0]      res_number_reg, res_number_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [NUM_W-1:0]      slot_number_reg, slot_number_next;
    logic [SLOT_COUNT-1:0] key_valid_reg, key_valid_next;
    logic [SLOT_COUNT-1:0] reserved_reg, reserved_next;

    logic                  accept;
    logic [KEY_BITS-1:0]   in_key;
    logic [KEY_BITS-1:0]   rd_data;
    logic                  chk_match;
    logic                  chk_free;
    logic                  chk_last;
    logic                  rsv_free;
    logic                  out_load;
    logic [REL_W-1:0]      rel_ext;
    logic                  rel_in_range;
    logic [IDX_W-1:0]      rel_idx;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_key   = lookup_key[KEY_BITS-1:0];

    // a slot holds a key exactly when its valid bit is set: stored keys are never zero
    assign chk_match = chk_valid_reg && key_valid_reg[chk_idx_reg] && (rd_data == key_reg);
    assign chk_free  = chk_valid_reg && !key_valid_reg[chk_idx_reg]
                       && !reserved_reg[chk_idx_reg];
    assign chk_last  = chk_valid_reg && (chk_idx_reg == IDX_W'(USABLE_SLOTS - 1));
    assign rsv_free  = !key_valid_reg[rsv_idx_reg] && !reserved_reg[rsv_idx_reg];
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign rel_ext      = {1'b0, release_number};
    assign rel_in_range = (rel_ext >= REL_W'(SLOT_BASE))
                          && (rel_ext < REL_W'(SLOT_BASE + USABLE_SLOTS));
    assign rel_idx      = IDX_W'(rel_ext - REL_W'(SLOT_BASE));

    // claim on the last compare when no earlier slot matched
    assign wr_en   = (state_reg == ST_SCAN) && chk_last && !chk_match
                     && (free_found_reg || chk_free);
    assign wr_addr = free_found_reg ? free_idx_reg : chk_idx_reg;

    dsa_key_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (KEY_BITS),
        .ADDR_W(IDX_W)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(key_reg),
        .rd_addr(iss_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_RESOLVE: state_next = (in_key == '0) ? ST_OUT : ST_SCAN;
                        OP_RESERVE: state_next = ST_RSV;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (chk_match || chk_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RSV:
            begin
                if (rsv_free || (rsv_idx_reg == '0))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_next        = key_reg;
        iss_next        = iss_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rsv_idx_next    = rsv_idx_reg;
        res_status_next = res_status_reg;
        res_number_next = res_number_reg;
        key_valid_next  = key_valid_reg;
        reserved_next   = reserved_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next        = in_key;
                    iss_next        = '0;
                    free_found_next = 1'b0;
                    rsv_idx_next    = IDX_W'(USABLE_SLOTS - 1);
                    res_status_next = STS_DONE;
                    res_number_next = '0;
                    unique case (op)
                        OP_RESOLVE:
                        begin
                            if (in_key == '0)
                            begin
                                res_status_next = STS_FAIL;
                            end
                        end
                        OP_RESERVE:
                        begin
                        end
                        OP_RELEASE:
                        begin
                            if (rel_in_range)
                            begin
                                reserved_next[rel_idx] = 1'b0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            key_valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (iss_reg < CNT_W'(USABLE_SLOTS))
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg[IDX_W-1:0];
                    iss_next       = iss_reg + 1'b1;
                end
                if (chk_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (chk_match)
                begin
                    res_status_next = STS_FOUND;
                    res_number_next = NUM_W'(SLOT_BASE) + NUM_W'(chk_idx_reg);
                end
                else if (chk_last)
                begin
                    if (free_found_reg || chk_free)
                    begin
                        key_valid_next[wr_addr] = 1'b1;
                        res_status_next = STS_DONE;
                        res_number_next = NUM_W'(SLOT_BASE) + NUM_W'(wr_addr);
                    end
                    else
                    begin
                        res_status_next = STS_FAIL;
                        res_number_next = '0;
                    end
                end
            end
            ST_RSV:
            begin
                if (rsv_free)
                begin
                    reserved_next[rsv_idx_reg] = 1'b1;
                    res_status_next = STS_DONE;
                    res_number_next = NUM_W'(SLOT_BASE) + NUM_W'(rsv_idx_reg);
                end
                else if (rsv_idx_reg == '0)
                begin
                    res_status_next = STS_FAIL;
                    res_number_next = '0;
                end
                else
                begin
                    rsv_idx_next = rsv_idx_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register lets the next word enter while this result waits
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        slot_number_next = slot_number_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            status_next      = res_status_reg;
            slot_number_next = res_number_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            key_valid_reg  <= '0;
            reserved_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
            key_valid_reg  <= key_valid_next;
            reserved_reg   <= reserved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        iss_reg         <= iss_next;
        chk_idx_reg     <= chk_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        rsv_idx_reg     <= rsv_idx_next;
        res_status_reg  <= res_status_next;
        res_number_reg  <= res_number_next;
        status_reg      <= status_next;
        slot_number_reg <= slot_number_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_number = slot_number_reg;

endmodule : dedup_slot_allocator_unit
`default_nettype wire

// ===== design/dsa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_checker
// port level checks of the dedup slot allocator, bound to the top level
// ----------------------------------------------------------------------------
module dsa_checker
    import dsa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [NUM_W-1:0]    slot_number
);

    logic [REL_W-1:0] num_ext;

    assign num_ext = {1'b0, slot_number};

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_number))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STS_DONE) || (status == STS_FOUND) || (status == STS_FAIL))
        else $error("unknown status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STS_FAIL) |-> (slot_number == '0))
        else $error("failed result with slot number");

    a_number_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slot_number != '0) |->
            (num_ext >= REL_W'(SLOT_BASE)) && (num_ext < REL_W'(SLOT_BASE + USABLE_SLOTS)))
        else $error("slot number outside the table");

endmodule : dsa_checker

bind dedup_slot_allocator_unit dsa_checker u_dsa_checker (.*);
`default_nettype wire

// ===== test/tb_dedup_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_slot_allocator_unit
// drives resolve, reserve, release and clear words into the slot allocator and
// checks every result word against a behavioral copy of the slot table or a typed-in expectation
// ----------------------------------------------------------------------------
module tb_dedup_slot_allocator_unit;
    import dsa_pkg::*;

    localparam int          ITEM_TARGET = 850;
    localparam int          POOL_SIZE   = 40;
    localparam logic [63:0] KEY_MASK    = (KEY_BITS >= 64) ? {64{1'b1}} :
                                          ((64'd1 << KEY_BITS) - 64'd1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    number;
    } answer_t;

    typedef struct {
        logic [OP_W-1:0]  code;
        logic [63:0]      key;
        logic [NUM_W-1:0] rel;
        bit               fixed;
        answer_t          answer;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     op;
    logic [63:0]         lookup_key;
    logic [NUM_W-1:0]    release_number;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    slot_number;

    // behavioral slot table
    logic [63:0] slot_key [SLOT_COUNT];
    bit          slot_rsv [SLOT_COUNT];

    answer_t     pending_answers [$];
    plan_row_t   plan [$];
    logic [63:0] key_pool [POOL_SIZE];
    int          mismatches = 0;
    int          words_sent = 0;
    bit          send_quiet = 1'b0;

    always #4 clk = ~clk;

    dedup_slot_allocator_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .lookup_key     (lookup_key),
        .release_number (release_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_number    (slot_number)
    );

    function automatic answer_t allocate_slot(input logic [OP_W-1:0]  code,
                                              input logic [63:0]      raw_key,
                                              input logic [NUM_W-1:0] rel);
        logic [63:0] key;
        int          rel_idx;
        key = raw_key & KEY_MASK;
        rel_idx = int'(rel) - SLOT_BASE;
        case (code)
            OP_RESOLVE:
            begin
                if (key == '0)
                    return '{STS_FAIL, '0};
                // dedup looks at every usable slot, reserved or not
                for (int i = 0; i < USABLE_SLOTS; i++)
                begin
                    if (slot_key[i] == key)
                        return '{STS_FOUND, NUM_W'(SLOT_BASE + i)};
                end
                for (int i = 0; i < USABLE_SLOTS; i++)
                begin
                    if (slot_key[i] == '0 && !slot_rsv[i])
                    begin
                        slot_key[i] = key;
                        return '{STS_DONE, NUM_W'(SLOT_BASE + i)};
                    end
                end
                return '{STS_FAIL, '0};
            end
            OP_RESERVE:
            begin
                for (int i = USABLE_SLOTS - 1; i >= 0; i--)
                begin
                    if (slot_key[i] == '0 && !slot_rsv[i])
                    begin
                        slot_rsv[i] = 1'b1;
                        return '{STS_DONE, NUM_W'(SLOT_BASE + i)};
                    end
                end
                return '{STS_FAIL, '0};
            end
            OP_RELEASE:
            begin
                if (rel_idx >= 0 && rel_idx < USABLE_SLOTS)
                    slot_rsv[rel_idx] = 1'b0;
                return '{STS_DONE, '0};
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    slot_key[i] = '0;
                return '{STS_DONE, '0};
            end
        endcase
        return '{STS_FAIL, '0};
    endfunction

    task automatic report_mismatch(input string what, input answer_t got, input answer_t want);
        $display("%0t ns: %s: got status %0d number %0d, want status %0d number %0d",
                 $time, what, got.status, got.number, want.status, want.number);
        mismatches++;
    endtask

    task automatic add_row(input logic [OP_W-1:0] code, input logic [63:0] key,
                           input logic [NUM_W-1:0] rel, input bit fixed,
                           input logic [STATUS_W-1:0] st, input int num);
        plan_row_t row;
        row.code   = code;
        row.key    = key;
        row.rel    = rel;
        row.fixed  = fixed;
        row.answer = '{st, NUM_W'(num)};
        plan.push_back(row);
    endtask

    task automatic send_word(input logic [OP_W-1:0] code, input logic [63:0] key,
                             input logic [NUM_W-1:0] rel, input bit fixed,
                             input answer_t typed);
        answer_t predicted;
        op             <= code;
        lookup_key     <= key;
        release_number <= rel;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = allocate_slot(code, key, rel);
        pending_answers.push_back(fixed ? typed : predicted);
        words_sent++;
    endtask

    task automatic idle_sender();
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 199) == 0)
            send_quiet = !send_quiet;
        if (send_quiet || r < 55)
            gap = 0;
        else if (r < 94)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 14)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [NUM_W-1:0] pick_release();
        int idx;
        if ($urandom_range(0, 4) != 0)
        begin
            for (int t = 0; t < 8; t++)
            begin
                idx = $urandom_range(0, USABLE_SLOTS - 1);
                if (slot_rsv[idx])
                    return NUM_W'(SLOT_BASE + idx);
            end
        end
        return NUM_W'($urandom);
    endfunction

    // result side: random stalls, mostly short, some long, with quiet stretches
    initial
    begin
        int  stall_left;
        bit  quiet;
        stall_left = 0;
        quiet      = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) == 0)
                quiet = !quiet;
            if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                           $urandom_range(1, 3);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, slot_number};
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected word", got, '0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got, want);
                if (got.number !== want.number)
                    report_mismatch("slot_number", got, want);
            end
        end
    end

    initial
    begin
        int        kind;
        int        len;
        int        r;
        int        lim_res;
        int        lim_rsv;
        int        lim_rel;
        int        epoch;
        logic [OP_W-1:0] code;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        op             <= OP_RESOLVE;
        lookup_key     <= '0;
        release_number <= '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_key[i] = '0;
            slot_rsv[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom} | 64'd1;

        // directed words; expectation typed in where it is obvious
        add_row(OP_RESOLVE, 64'd0,            11'd0,    1, STS_FAIL,  0);
        add_row(OP_RESOLVE, {64{1'b1}},       11'd0,    1, STS_DONE,  SLOT_BASE);
        add_row(OP_RESOLVE, {64{1'b1}},       11'd0,    1, STS_FOUND, SLOT_BASE);
        add_row(OP_RESOLVE, 64'd1,            11'd2047, 1, STS_DONE,  SLOT_BASE + 1);
        add_row(OP_RESOLVE, 64'h8000_0000_0000_0000, 11'd0, 1, STS_DONE, SLOT_BASE + 2);
        add_row(OP_RESERVE, {64{1'b1}},       11'd0,    1, STS_DONE,
                SLOT_BASE + USABLE_SLOTS - 1);
        add_row(OP_RESERVE, 64'd0,            11'd2047, 1, STS_DONE,
                SLOT_BASE + USABLE_SLOTS - 2);
        add_row(OP_RELEASE, 64'd0, NUM_W'(SLOT_BASE + USABLE_SLOTS - 1), 1, STS_DONE, 0);
        add_row(OP_RELEASE, 64'd0, NUM_W'(SLOT_BASE - 1),                1, STS_DONE, 0);
        add_row(OP_RELEASE, 64'd0, NUM_W'(SLOT_BASE + USABLE_SLOTS),     1, STS_DONE, 0);
        add_row(OP_RELEASE, {64{1'b1}}, 11'd2047, 1, STS_DONE, 0);
        add_row(OP_RELEASE, 64'd0,      11'd0,    1, STS_DONE, 0);
        add_row(OP_RESOLVE, 64'h5555_5555_5555_5555, 11'h555, 0, STS_DONE, 0);
        add_row(OP_RESOLVE, 64'hAAAA_AAAA_AAAA_AAAA, 11'h2AA, 0, STS_DONE, 0);
        add_row(OP_RESERVE, 64'd0,      11'd0,    0, STS_DONE, 0);
        add_row(OP_RESOLVE, 64'd1,      11'd0,    0, STS_DONE, 0);
        add_row(OP_CLEAR,   {64{1'b1}}, 11'd2047, 1, STS_DONE, 0);
        add_row(OP_RESOLVE, 64'd1,      11'd0,    0, STS_DONE, 0);
        add_row(OP_RESOLVE, {64{1'b1}}, 11'd0,    0, STS_DONE, 0);
        add_row(OP_RESERVE, 64'd0,      11'd0,    0, STS_DONE, 0);
        add_row(OP_RELEASE, 64'd0, NUM_W'(SLOT_BASE + USABLE_SLOTS - 2), 0, STS_DONE, 0);
        add_row(OP_RELEASE, 64'd0, NUM_W'(SLOT_BASE),                    0, STS_DONE, 0);
        add_row(OP_RESERVE, 64'd0,      11'd0,    0, STS_DONE, 0);
        add_row(OP_CLEAR,   64'd0,      11'd0,    0, STS_DONE, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_word(plan[i].code, plan[i].key, plan[i].rel, plan[i].fixed, plan[i].answer);
            idle_sender();
        end

        // random epochs, each leaning toward one kind of traffic
        epoch = 0;
        while (words_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(20, 70);
            case (kind)
                0:       begin lim_res = 80; lim_rsv = 88; lim_rel = 98; end
                1:       begin lim_res = 25; lim_rsv = 75; lim_rel = 98; end
                2:       begin lim_res = 50; lim_rsv = 70; lim_rel = 98; end
                default: begin lim_res = 40; lim_rsv = 55; lim_rel = 99; end
            endcase
            for (int k = 0; k < len && words_sent < ITEM_TARGET; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < lim_res)
                    code = OP_RESOLVE;
                else if (r < lim_rsv)
                    code = OP_RESERVE;
                else if (r < lim_rel)
                    code = OP_RELEASE;
                else
                    code = OP_CLEAR;
                send_word(code, (code == OP_RESOLVE) ? pick_key() : {$urandom, $urandom},
                          (code == OP_RELEASE) ? pick_release() : NUM_W'($urandom),
                          1'b0, '0);
                idle_sender();
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_word(OP_CLEAR, {$urandom, $urandom}, NUM_W'($urandom), 1'b0, '0);
                idle_sender();
                if ($urandom_range(0, 1) == 0)
                    for (int i = 0; i < POOL_SIZE; i++)
                        key_pool[i] = {$urandom, $urandom} | 64'd1;
            end
            // hold off until the allocator has answered everything
            if (epoch == 2 || $urandom_range(0, 7) == 0)
                drain_answers();
            epoch++;
        end

        drain_answers();
        repeat (USABLE_SLOTS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/dsa_pkg.sv
design/dsa_key_ram.sv
design/dedup_slot_allocator_unit.sv
design/dsa_checker.sv
test/tb_dedup_slot_allocator_unit.sv
